[design/rcat_pkg.sv]
// Package for the reference count aging table.
// Holds item types, status codes and default sizes; no dependencies.
`timescale 1ns / 1ps

package rcat_pkg;

    localparam int ENTRIES_DEF    = 64;
    localparam int COUNT_BITS_DEF = 16;
    localparam int KEY_W          = 32;
    localparam int OCC_W          = 7;
    localparam int STATUS_W       = 2;

    localparam logic MODE_REF   = 1'b0;
    localparam logic MODE_CLEAN = 1'b1;

    localparam logic [STATUS_W-1:0] ST_HIT      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLEAN    = 2'd3;

    typedef struct packed {
        logic                    mode;
        logic signed [KEY_W-1:0] key;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
        logic [OCC_W-1:0]    evicted;
    } rsp_item_t;

endpackage

[design/rcat_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rcat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/reference_count_aging_table_top.sv]
// Top level of the reference count aging table: control sequencer and entry store.
// Depends on rcat_pkg and rcat_ram.
//
//   channel | dir | handshake               | payload
//   req     | in  | req_valid / req_ready   | req_item_t  (mode, key)
//   rsp     | out | rsp_valid / rsp_ready   | rsp_item_t  (status, occupancy, evicted)
//
// A clean or a miss walks every slot of the entry RAM, one read per cycle.
// A hit at slot i ends the walk.
// After reset a clearing pass writes every slot, with req_ready low.
// One item is in work at a time; a finished result waits in the output register
// while the next item is accepted.
`timescale 1ns / 1ps

module reference_count_aging_table_top
    import rcat_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int MW    = 1 + KEY_W + COUNT_BITS;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_AGE    = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  have_free_reg, have_free_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]      gone_reg, gone_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [CNT_W-1:0]      res_evicted_reg, res_evicted_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_item_t             rsp_reg;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [MW-1:0]         mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    logic [MW-1:0]         mem_rdata;

    logic                  rd_valid;
    logic [KEY_W-1:0]      rd_key;
    logic [COUNT_BITS-1:0] rd_count;
    logic                  last;
    logic                  hit;
    logic                  evict_now;
    logic                  out_free;
    logic [CNT_W-1:0]      gone_now;
    logic [CNT_W+OCC_W-1:0] occ_wide;
    logic [CNT_W+OCC_W-1:0] evc_wide;

    rcat_ram #(
        .WIDTH (MW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_valid  = mem_rdata[MW-1];
    assign rd_key    = mem_rdata[COUNT_BITS +: KEY_W];
    assign rd_count  = mem_rdata[COUNT_BITS-1:0];
    assign last      = (cmp_idx_reg == IDX_W'(ENTRIES - 1));
    assign hit       = rd_valid && (rd_key == key_reg);
    assign evict_now = rd_valid && (rd_count <= COUNT_BITS'(1));
    assign gone_now  = gone_reg + CNT_W'(evict_now);
    assign out_free  = !rsp_valid_reg || rsp_ready;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next       = state_reg;
        cmp_idx_next     = cmp_idx_reg;
        have_free_next   = have_free_reg;
        free_idx_next    = free_idx_reg;
        gone_next        = gone_reg;
        total_next       = total_reg;
        key_next         = key_reg;
        res_status_next  = res_status_reg;
        res_evicted_next = res_evicted_reg;
        mem_we           = 1'b0;
        mem_waddr        = cmp_idx_reg;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = cmp_idx_reg + IDX_W'(1);

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (last)
                begin
                    cmp_idx_next = '0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmp_idx_next = cmp_idx_reg + IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = '0;
                    cmp_idx_next   = '0;
                    key_next       = req.key;
                    have_free_next = 1'b0;
                    gone_next      = '0;
                    state_next     = (req.mode == MODE_CLEAN) ? S_AGE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                mem_re       = !last;
                cmp_idx_next = cmp_idx_reg + IDX_W'(1);
                if (hit)
                begin
                    mem_we = 1'b1;
                    mem_wdata = {1'b1, key_reg,
                                 (rd_count == '1) ? rd_count : rd_count + COUNT_BITS'(1)};
                    res_status_next  = ST_HIT;
                    res_evicted_next = '0;
                    state_next       = S_FINISH;
                end
                else
                begin
                    if (!rd_valid && !have_free_reg)
                    begin
                        have_free_next = 1'b1;
                        free_idx_next  = cmp_idx_reg;
                    end
                    if (last)
                    begin
                        res_evicted_next = '0;
                        state_next       = S_FINISH;
                        if (have_free_reg || !rd_valid)
                        begin
                            mem_we           = 1'b1;
                            mem_waddr        = have_free_reg ? free_idx_reg : cmp_idx_reg;
                            mem_wdata        = {1'b1, key_reg, COUNT_BITS'(1)};
                            total_next       = total_reg + CNT_W'(1);
                            res_status_next  = ST_INSERTED;
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                        end
                    end
                end
            end
            S_AGE:
            begin
                mem_re       = !last;
                cmp_idx_next = cmp_idx_reg + IDX_W'(1);
                gone_next    = gone_now;
                if (rd_valid)
                begin
                    mem_we = 1'b1;
                    if (evict_now)
                    begin
                        mem_wdata = {1'b0, rd_key, COUNT_BITS'(0)};
                    end
                    else
                    begin
                        mem_wdata = {1'b1, rd_key, rd_count - COUNT_BITS'(1)};
                    end
                end
                if (last)
                begin
                    total_next       = total_reg - gone_now;
                    res_status_next  = ST_CLEAN;
                    res_evicted_next = gone_now;
                    state_next       = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign occ_wide = {{OCC_W{1'b0}}, total_reg};
    assign evc_wide = {{OCC_W{1'b0}}, res_evicted_reg};

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if ((state_reg == S_FINISH) && out_free)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cmp_idx_reg   <= '0;
            have_free_reg <= 1'b0;
            gone_reg      <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_idx_reg   <= cmp_idx_next;
            have_free_reg <= have_free_next;
            gone_reg      <= gone_next;
            total_reg     <= total_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_idx_reg    <= free_idx_next;
        key_reg         <= key_next;
        res_status_reg  <= res_status_next;
        res_evicted_reg <= res_evicted_next;
        if ((state_reg == S_FINISH) && out_free)
        begin
            rsp_reg.status    <= res_status_reg;
            rsp_reg.occupancy <= occ_wide[OCC_W-1:0];
            rsp_reg.evicted   <= evc_wide[OCC_W-1:0];
        end
    end

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && mem_re |-> mem_waddr != mem_raddr)
        else $error("entry RAM read and write hit the same slot");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(ENTRIES))
        else $error("occupancy exceeds table size");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=>
            ((state_reg == S_AGE) == ($past(req.mode) == MODE_CLEAN)) &&
            ((state_reg == S_SCAN) || (state_reg == S_AGE)))
        else $error("accepted item dispatched to wrong walk");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside finish");

    a_ref_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.status != ST_CLEAN) |-> rsp_reg.evicted == '0)
        else $error("reference item reports evictions");

endmodule
